// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/p4g_pkg.sv =====
package p4g_pkg;

    localparam int GLYPH_COUNT_DEF = 96;
    localparam int FIRST_CODE_DEF  = 32;

    localparam int CELL_W    = 4;
    localparam int CELL_H    = 6;
    localparam int PIX_COUNT = CELL_W * CELL_H;

    localparam int GLYPH_W = 16;
    localparam int CODE_W  = 8;
    localparam int COORD_W = 13;
    localparam int COLOR_W = 32;

    localparam logic [GLYPH_W-1:0] ROW_MASK  = 16'h000e;
    localparam logic [GLYPH_W-1:0] MID_HIGH  = 16'h0300;
    localparam logic [GLYPH_W-1:0] MID_LOW   = 16'h0002;

    typedef enum logic
    {
        OP_DRAW = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    // One packed row of the glyph; the middle row is split across the word.
    function automatic logic [CELL_W-1:0] row_bits(input logic [GLYPH_W-1:0] g,
                                                   input logic [2:0] j);
        logic [2:0]         r;
        logic [GLYPH_W-1:0] w;
        r = j - {2'b00, g[0]};
        w = '0;
        if (j >= {2'b00, g[0]})
        begin
            case (r)
                3'd0: w = (g >> 12) & ROW_MASK;
                3'd1: w = (g >> 9) & ROW_MASK;
                3'd2: w = ((g & MID_HIGH) >> 6) | (g & MID_LOW);
                3'd3: w = (g >> 4) & ROW_MASK;
                3'd4: w = (g >> 1) & ROW_MASK;
                default: w = '0;
            endcase
        end
        return w[CELL_W-1:0];
    endfunction

    // Set-pixel map in scan order: bit j*4+i is row j, column i.
    function automatic logic [PIX_COUNT-1:0] glyph_pixels(input logic [GLYPH_W-1:0] g);
        logic [PIX_COUNT-1:0] m;
        m = '0;
        for (int j = 0; j < CELL_H; j++)
        begin
            m[j*CELL_W +: CELL_W] = row_bits(g, 3'(j));
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/p4g_ram.sv =====
module p4g_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 96,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/packed_4x6_glyph_renderer_top.sv =====
// Channel   Handshake            Payload
// request   in_valid / in_stall  operation, char_code, glyph_word, origin_x, origin_y,
//                                fore_color, back_color, fill_background
// pixel     out_valid/out_stall  pixel_x, pixel_y, pixel_color, last_pixel
//
// A load writes the table. A draw reads the table in the cycle it is accepted,
// then scans its 24 cells one per cycle, holding on a cell to emit while the
// output is stalled, and stops after the last pixel it emits. Draws follow each
// other without a gap. Reset clears all control; the table is undefined until
// loaded. A stalled output holds the scan, which in turn stalls requests.
`include "assert_macros.svh"

module packed_4x6_glyph_renderer_top #(
    parameter int GLYPH_COUNT = p4g_pkg::GLYPH_COUNT_DEF,
    parameter int FIRST_CODE  = p4g_pkg::FIRST_CODE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [7:0]         char_code,
    input  logic [15:0]        glyph_word,
    input  logic signed [11:0] origin_x,
    input  logic signed [11:0] origin_y,
    input  logic [31:0]        fore_color,
    input  logic [31:0]        back_color,
    input  logic               fill_background,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [12:0] pixel_x,
    output logic signed [12:0] pixel_y,
    output logic [31:0]        pixel_color,
    output logic               last_pixel
);
    import p4g_pkg::*;

    localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

    // request decode
    logic             in_acc;
    logic [8:0]       slot_diff;
    logic             in_range;
    logic             is_load;
    logic             tab_we;
    logic             tab_re;
    logic [GLYPH_W-1:0] tab_rdata;

    // stage A: table read in flight
    logic               a_valid_reg, a_valid_next;
    logic signed [11:0] a_x_reg, a_y_reg;
    logic [COLOR_W-1:0] a_fg_reg, a_bg_reg;
    logic               a_fill_reg;
    logic               a_adv;

    // stage B: cell scan
    logic                   b_valid_reg, b_valid_next;
    logic [PIX_COUNT-1:0]   b_emit_reg, b_emit_next;
    logic [PIX_COUNT-1:0]   b_set_reg, b_set_next;
    logic [4:0]             b_pos_reg, b_pos_next;
    logic signed [COORD_W-1:0] b_xb_reg, b_xb_next;
    logic signed [COORD_W-1:0] b_yb_reg, b_yb_next;
    logic [COLOR_W-1:0]     b_fg_reg, b_fg_next;
    logic [COLOR_W-1:0]     b_bg_reg, b_bg_next;
    logic                   b_step;
    logic                   b_last;
    logic                   b_free;
    logic                   out_free;
    logic [PIX_COUNT-1:0]   new_emit;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [COORD_W-1:0] px_reg, px_next;
    logic signed [COORD_W-1:0] py_reg, py_next;
    logic [COLOR_W-1:0]        pc_reg, pc_next;
    logic                      pl_reg, pl_next;

    assign in_acc    = in_valid && !in_stall;
    assign slot_diff = {1'b0, char_code} - 9'(FIRST_CODE);
    assign in_range  = !slot_diff[8] && (slot_diff < 9'(GLYPH_COUNT));
    assign is_load   = (op_t'(operation) == OP_LOAD);
    assign tab_we    = in_acc && in_range && is_load;
    assign tab_re    = in_acc && in_range && !is_load;

    p4g_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (GLYPH_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (slot_diff[AW-1:0]),
        .wdata (glyph_word),
        .re    (tab_re),
        .raddr (slot_diff[AW-1:0]),
        .rdata (tab_rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign b_step   = b_valid_reg && (!b_emit_reg[0] || out_free);
    assign b_last   = (b_emit_reg[PIX_COUNT-1:1] == '0);
    assign b_free   = !b_valid_reg || (b_step && b_last);
    assign a_adv    = a_valid_reg && b_free;
    assign in_stall = a_valid_reg && !b_free;
    assign new_emit = glyph_pixels(tab_rdata) | {PIX_COUNT{a_fill_reg}};

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_adv)
        begin
            a_valid_next = 1'b0;
        end
        if (tab_re)
        begin
            a_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        b_emit_next  = b_emit_reg;
        b_set_next   = b_set_reg;
        b_pos_next   = b_pos_reg;
        b_xb_next    = b_xb_reg;
        b_yb_next    = b_yb_reg;
        b_fg_next    = b_fg_reg;
        b_bg_next    = b_bg_reg;
        if (b_step)
        begin
            b_emit_next = b_emit_reg >> 1;
            b_set_next  = b_set_reg >> 1;
            b_pos_next  = b_pos_reg + 5'd1;
            if (b_last)
            begin
                b_valid_next = 1'b0;
            end
        end
        if (a_adv)
        begin
            // skip the scan entirely when nothing would be drawn
            b_valid_next = (new_emit != '0);
            b_emit_next  = new_emit;
            b_set_next   = glyph_pixels(tab_rdata);
            b_pos_next   = '0;
            b_xb_next    = {a_x_reg[11], a_x_reg} + 13'sd3;
            b_yb_next    = {a_y_reg[11], a_y_reg} + 13'sd5;
            b_fg_next    = a_fg_reg;
            b_bg_next    = a_bg_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pc_next        = pc_reg;
        pl_next        = pl_reg;
        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (b_step && b_emit_reg[0])
        begin
            out_valid_next = 1'b1;
            px_next        = b_xb_reg - signed'({11'd0, b_pos_reg[1:0]});
            py_next        = b_yb_reg - signed'({10'd0, b_pos_reg[4:2]});
            pc_next        = b_set_reg[0] ? b_fg_reg : b_bg_reg;
            pl_next        = b_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tab_re)
        begin
            a_x_reg    <= origin_x;
            a_y_reg    <= origin_y;
            a_fg_reg   <= fore_color;
            a_bg_reg   <= back_color;
            a_fill_reg <= fill_background;
        end
        b_emit_reg <= b_emit_next;
        b_set_reg  <= b_set_next;
        b_pos_reg  <= b_pos_next;
        b_xb_reg   <= b_xb_next;
        b_yb_reg   <= b_yb_next;
        b_fg_reg   <= b_fg_next;
        b_bg_reg   <= b_bg_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        pc_reg     <= pc_next;
        pl_reg     <= pl_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = pc_reg;
    assign last_pixel  = pl_reg;

    `ASSERT_IMPL(a_scan_nonempty, clk, rst_n, b_valid_reg, b_emit_reg != '0)
    `ASSERT_IMPL(a_stall_only_full, clk, rst_n, !a_valid_reg, !in_stall)
    `ASSERT_NEXT(a_emit_shows, clk, rst_n, b_step && b_emit_reg[0], out_valid)
    `ASSERT_NEXT(a_read_holds, clk, rst_n, a_valid_reg && !b_free, a_valid_reg)

endmodule

// ===== verif/tb.sv =====
module tb;
    import p4g_pkg::*;

    localparam int FIRST_CODE  = FIRST_CODE_DEF;
    localparam int GLYPH_COUNT = GLYPH_COUNT_DEF;
    localparam int IDLE_MAX    = 18;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed
    {
        logic signed [12:0] x;
        logic signed [12:0] y;
        logic [31:0]        color;
        logic               last;
    } pixel_write_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               operation = OP_DRAW;
    logic [7:0]         char_code = '0;
    logic [15:0]        glyph_word = '0;
    logic signed [11:0] origin_x = '0;
    logic signed [11:0] origin_y = '0;
    logic [31:0]        fore_color = '0;
    logic [31:0]        back_color = '0;
    logic               fill_background = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [12:0] pixel_x;
    logic signed [12:0] pixel_y;
    logic [31:0]        pixel_color;
    logic               last_pixel;

    logic [15:0]  font_rom [GLYPH_COUNT];
    bit           slot_loaded [GLYPH_COUNT];
    int           loaded_slots [$];
    pixel_write_t pixels_due [$];
    pixel_write_t due_pixel;

    int  error_count = 0;
    int  cycle_count = 0;
    int  draw_count = 0;
    int  load_count = 0;
    int  ignored_count = 0;
    int  pixel_count = 0;
    int  tx_gap_max = 0;
    int  rx_stall_max = 0;
    int  rx_stall_left = 0;
    int  rx_hold_cycles = 0;
    bit  pixel_taken = 1'b0;

    packed_4x6_glyph_renderer_top uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .char_code       (char_code),
        .glyph_word      (glyph_word),
        .origin_x        (origin_x),
        .origin_y        (origin_y),
        .fore_color      (fore_color),
        .back_color      (back_color),
        .fill_background (fill_background),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .pixel_color     (pixel_color),
        .last_pixel      (last_pixel)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d pixel writes pending", $time, pixels_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Unpack one cell row; the middle row is split across the word.
    function automatic logic [3:0] glyph_row(input logic [15:0] g, input int j);
        int          r;
        logic [15:0] w;
        r = j - int'(g[0]);
        w = '0;
        case (r)
            0: w = (g >> 12) & ROW_MASK;
            1: w = (g >> 9) & ROW_MASK;
            2: w = ((g & MID_HIGH) >> 6) | (g & MID_LOW);
            3: w = (g >> 4) & ROW_MASK;
            4: w = (g >> 1) & ROW_MASK;
            default: w = '0;
        endcase
        return w[3:0];
    endfunction

    task automatic render_request(input op_t op, input logic [7:0] code,
                                  input logic [15:0] glyph,
                                  input logic signed [11:0] ox, input logic signed [11:0] oy,
                                  input logic [31:0] fg, input logic [31:0] bg,
                                  input logic fill);
        int                 slot;
        logic [15:0]        g;
        logic [3:0]         row;
        logic signed [12:0] bx;
        logic signed [12:0] by;
        pixel_write_t       held;
        pixel_write_t       px;
        bit                 have_held;
        if (code < FIRST_CODE || code >= FIRST_CODE + GLYPH_COUNT)
        begin
            ignored_count++;
            return;
        end
        slot = code - FIRST_CODE;
        if (op == OP_LOAD)
        begin
            font_rom[slot] = glyph;
            if (!slot_loaded[slot])
            begin
                slot_loaded[slot] = 1'b1;
                loaded_slots.push_back(slot);
            end
            load_count++;
            return;
        end
        g = font_rom[slot];
        bx = ox;
        by = oy;
        have_held = 1'b0;
        held = '0;
        for (int j = 0; j < CELL_H; j++)
        begin
            row = glyph_row(g, j);
            for (int i = 0; i < CELL_W; i++)
            begin
                if (row[i] || fill)
                begin
                    px.x = bx + 13'sd3 - 13'(i);
                    px.y = by + 13'sd5 - 13'(j);
                    px.color = row[i] ? fg : bg;
                    px.last = 1'b0;
                    // hold back one write so the final one can be marked
                    if (have_held)
                        pixels_due.push_back(held);
                    held = px;
                    have_held = 1'b1;
                end
            end
        end
        if (have_held)
        begin
            held.last = 1'b1;
            pixels_due.push_back(held);
        end
        draw_count++;
    endtask

    // Entered and left at a falling edge; valid stays high into the next request.
    task automatic send_request(input op_t op, input logic [7:0] code,
                                input logic [15:0] glyph,
                                input logic signed [11:0] ox, input logic signed [11:0] oy,
                                input logic [31:0] fg, input logic [31:0] bg,
                                input logic fill);
        int gap;
        gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        operation       <= op;
        char_code       <= code;
        glyph_word      <= glyph;
        origin_x        <= ox;
        origin_y        <= oy;
        fore_color      <= fg;
        back_color      <= bg;
        fill_background <= fill;
        do
            @(posedge clk);
        while (in_stall);
        render_request(op, code, glyph, ox, oy, fg, bg, fill);
        @(negedge clk);
    endtask

    task automatic pause_requests;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pixels_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [11:0] pick_coord;
        case ($urandom_range(0, 5))
            0: return 12'h7ff;
            1: return 12'h800;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_glyph;
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'hfffe;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_glyph(input logic [7:0] code, input logic [15:0] word);
        send_request(OP_LOAD, code, word, 12'($urandom), 12'($urandom), $urandom, $urandom,
                     1'($urandom));
    endtask

    task automatic draw_char(input logic [7:0] code, input logic signed [11:0] ox,
                             input logic signed [11:0] oy, input logic [31:0] fg,
                             input logic [31:0] bg, input logic fill);
        send_request(OP_DRAW, code, 16'($urandom), ox, oy, fg, bg, fill);
    endtask

    // Draw only slots that hold a loaded glyph.
    task automatic draw_loaded(input logic fill);
        int slot;
        slot = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
        draw_char(8'(FIRST_CODE + slot), pick_coord(), pick_coord(), $urandom, $urandom, fill);
    endtask

    task automatic send_random_request;
        int       k;
        logic [7:0] code;
        k = $urandom_range(0, 99);
        if (k < 20)
            load_glyph(8'(FIRST_CODE + $urandom_range(0, GLYPH_COUNT - 1)), pick_glyph());
        else if (k < 28)
        begin
            code = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, FIRST_CODE - 1))
                                               : 8'($urandom_range(FIRST_CODE + GLYPH_COUNT, 255));
            send_request(op_t'($urandom_range(0, 1)), code, 16'($urandom), pick_coord(),
                         pick_coord(), $urandom, $urandom, 1'($urandom));
        end
        else
            draw_loaded(1'($urandom));
    endtask

    task automatic test_directed_glyphs;
        tx_gap_max = 0;
        rx_stall_max = 0;
        load_glyph(8'(FIRST_CODE), 16'hffff);
        load_glyph(8'(FIRST_CODE + GLYPH_COUNT - 1), 16'hfffe);
        load_glyph(8'd65, 16'h0000);
        load_glyph(8'd80, 16'h0302);
        load_glyph(8'd81, 16'h0001);
        draw_char(8'(FIRST_CODE), 12'sh7ff, 12'sh7ff, 32'hffffffff, 32'h0, 1'b0);
        draw_char(8'(FIRST_CODE + GLYPH_COUNT - 1), 12'sh800, 12'sh800, 32'h0,
                  32'hffffffff, 1'b1);
        // empty glyph: nothing in foreground mode, all background otherwise
        draw_char(8'd65, 12'sh000, 12'sh000, 32'h12345678, 32'h9abcdef0, 1'b0);
        draw_char(8'd65, 12'sh000, 12'sh000, 32'h12345678, 32'h9abcdef0, 1'b1);
        draw_char(8'd80, 12'sh7fc, 12'sh805, 32'hffffffff, 32'h0, 1'b0);
        draw_char(8'd81, 12'sh123, 12'shedc, 32'ha5a5a5a5, 32'h5a5a5a5a, 1'b1);
        // codes outside the table: dropped
        draw_char(8'(FIRST_CODE - 1), 12'sh000, 12'sh000, 32'hffffffff, 32'h0, 1'b1);
        draw_char(8'(FIRST_CODE + GLYPH_COUNT), 12'sh000, 12'sh000, 32'hffffffff, 32'h0, 1'b1);
        draw_char(8'd0, 12'sh7ff, 12'sh800, 32'hffffffff, 32'hffffffff, 1'b1);
        draw_char(8'd255, 12'sh800, 12'sh7ff, 32'hffffffff, 32'hffffffff, 1'b1);
        load_glyph(8'(FIRST_CODE - 1), 16'hffff);
        load_glyph(8'(FIRST_CODE + GLYPH_COUNT), 16'hffff);
        load_glyph(8'd255, 16'hffff);
        // reload a slot and draw it right behind the load
        load_glyph(8'(FIRST_CODE), 16'h5a5a);
        draw_char(8'(FIRST_CODE), 12'sh001, 12'sh002, 32'h0f0f0f0f, 32'hf0f0f0f0, 1'b1);
    endtask

    task automatic test_backpressure;
        tx_gap_max = 0;
        rx_stall_max = 0;
        rx_hold_cycles = 300;
        repeat (20) draw_loaded(1'b1);
    endtask

    task automatic test_drain_pause;
        tx_gap_max = IDLE_MAX;
        rx_stall_max = IDLE_MAX;
        repeat (10) draw_loaded(1'($urandom));
        pause_requests();
        repeat (10) send_random_request();
    endtask

    task automatic test_random_text;
        for (int phase = 0; phase < 5; phase++)
        begin
            // alternate busy and idle stretches on both sides
            tx_gap_max = (phase == 1 || phase == 3) ? 0 : IDLE_MAX;
            rx_stall_max = (phase == 1 || phase == 2) ? 0 : IDLE_MAX;
            repeat (50) send_random_request();
        end
    endtask

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            pixel_taken = 1'b1;
            if (pixels_due.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected pixel write, expected none, actual x=%0d y=%0d color=%h",
                         $time, pixel_x, pixel_y, pixel_color);
            end
            else
            begin
                due_pixel = pixels_due.pop_front();
                pixel_count++;
                check_field("pixel_x", due_pixel.x, pixel_x);
                check_field("pixel_y", due_pixel.y, pixel_y);
                check_field("pixel_color", due_pixel.color, pixel_color);
                check_field("last_pixel", due_pixel.last, last_pixel);
            end
        end
    end

    // Receiver: a long hold when asked, else a random stall after each pixel.
    always @(negedge clk)
    begin
        if (pixel_taken)
        begin
            pixel_taken = 1'b0;
            rx_stall_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, rx_stall_max);
        end
        if (rx_hold_cycles > 0)
        begin
            rx_hold_cycles--;
            out_stall <= 1'b1;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_glyphs();
        test_backpressure();
        test_drain_pause();
        test_random_text();
        in_valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (2 * PIX_COUNT) @(posedge clk);
        if (pixels_due.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d pixel writes never arrived", $time, pixels_due.size());
        end
        $display("covered %0d character draws, %0d glyph loads, %0d out-of-range codes",
                 draw_count, load_count, ignored_count);
        $display("checked %0d pixel writes, %0d errors", pixel_count, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
